/* rtl/gmt_pkg.sv */
// shared types and constants of the gradient magnitude threshold block
`default_nettype none

package gmt_pkg;

    localparam int MAX_WIDTH_DEF = 2048;

    localparam int PIX_W     = 8;
    localparam int ROW_W     = 16;
    localparam int COL_W     = 11;
    localparam int ROW_CNT_W = ROW_W + 1;
    localparam int FW_W      = 12;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    localparam logic [PIX_W-1:0] THRESHOLD_RST = 8'd150;
    localparam logic [FW_W-1:0]  WIDTH_RST     = 12'd640;
    localparam logic [ROW_W-1:0] HEIGHT_RST    = 16'd480;
    localparam int               MIN_DIM       = 3;
    localparam logic [PIX_W-1:0] EDGE_ON       = 8'd255;
    localparam logic [PIX_W-1:0] EDGE_OFF      = 8'd0;

    // half-pixel differences are 7 bits, sum of two squares fits 15 bits
    localparam int                 DIFF_W  = PIX_W - 1;
    localparam int                 SQ_W    = 2 * DIFF_W + 1;
    localparam int                 ROOT_W  = 8;
    localparam logic [SQ_W-1:0]    SQ_TOP  = SQ_W'(1) << (SQ_W - 1);

    typedef enum logic [1:0] {
        REG_THRESHOLD    = 2'd0,
        REG_FRAME_WIDTH  = 2'd1,
        REG_FRAME_HEIGHT = 2'd2,
        REG_SPARE        = 2'd3
    } gmt_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_SQUARE,
        ST_ROOT,
        ST_EMIT
    } gmt_state_t;

endpackage

`default_nettype wire

/* rtl/gmt_if.sv */
// pixel request and result request channel interfaces
`default_nettype none

interface gmt_pix_if;
    logic                        valid;
    logic                        ready;
    logic [gmt_pkg::PIX_W-1:0]   pixel;
    logic                        flush;

    modport source (output valid, output pixel, output flush, input ready);
    modport sink   (input valid, input pixel, input flush, output ready);
endinterface

interface gmt_res_if;
    logic                        valid;
    logic                        ready;
    logic [gmt_pkg::PIX_W-1:0]   magnitude;
    logic [gmt_pkg::PIX_W-1:0]   edge_value;
    logic [gmt_pkg::ROW_W-1:0]   row_index;
    logic [gmt_pkg::COL_W-1:0]   col_index;
    logic                        frame_last;

    modport source (output valid, output magnitude, output edge_value, output row_index,
                    output col_index, output frame_last, input ready);
    modport sink   (input valid, input magnitude, input edge_value, input row_index,
                    input col_index, input frame_last, output ready);
endinterface

`default_nettype wire

/* rtl/gradient_magnitude_threshold_core.sv */
// top level of the gradient magnitude threshold edge detector
//
//   channel   direction  handshake           payload
//   pix_in    in         valid / ready       pixel, flush
//   res_out   out        valid / ready       magnitude, edge_value, row_index,
//                                            col_index, frame_last
//   apb       in         psel / penable      paddr, pwdata, prdata (pready tied high)
//
// an item giving a result passes through request and line store read, window update,
// squaring, the bit-serial square root unit and output load
// an item giving no result (first row and first item of the second row) ends after the window update
// line stores are not cleared after reset; window and counters reset to zero
// a waiting result sits in the output register while the next pixel is taken;
// the next result waits in its last cycle until that register drains

`default_nettype none

module gradient_magnitude_threshold_core #(
    parameter int MAX_WIDTH = gmt_pkg::MAX_WIDTH_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    gmt_pix_if.sink                           pix_in,
    gmt_res_if.source                         res_out,
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [gmt_pkg::PADDR_W-1:0]       paddr,
    input  wire  [gmt_pkg::PDATA_W-1:0]       pwdata,
    output logic [gmt_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = (CW + 1 > gmt_pkg::FW_W) ? CW + 1 : gmt_pkg::FW_W;
    localparam int PW = gmt_pkg::PIX_W;
    localparam int DW = gmt_pkg::DIFF_W;
    localparam int RW = gmt_pkg::ROW_W;
    localparam int RCW = gmt_pkg::ROW_CNT_W;

    // configuration registers
    logic [PW-1:0]               thr_reg;
    logic [gmt_pkg::FW_W-1:0]    fw_reg;
    logic [RW-1:0]               fh_reg;
    logic                        cfg_wr;
    gmt_pkg::gmt_reg_t           cfg_sel;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = gmt_pkg::gmt_reg_t'(paddr[3:2]);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= gmt_pkg::THRESHOLD_RST;
            fw_reg  <= gmt_pkg::WIDTH_RST;
            fh_reg  <= gmt_pkg::HEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                gmt_pkg::REG_THRESHOLD:    thr_reg <= pwdata[PW-1:0];
                gmt_pkg::REG_FRAME_WIDTH:  fw_reg  <= pwdata[gmt_pkg::FW_W-1:0];
                gmt_pkg::REG_FRAME_HEIGHT: fh_reg  <= pwdata[RW-1:0];
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            gmt_pkg::REG_THRESHOLD:    prdata = gmt_pkg::PDATA_W'(thr_reg);
            gmt_pkg::REG_FRAME_WIDTH:  prdata = gmt_pkg::PDATA_W'(fw_reg);
            gmt_pkg::REG_FRAME_HEIGHT: prdata = gmt_pkg::PDATA_W'(fh_reg);
            default:                   prdata = '0;
        endcase
    end

    // effective frame size
    logic [WW-1:0] fw_ext;
    logic [WW-1:0] w_eff;
    logic [RW-1:0] h_eff;

    assign fw_ext = WW'(fw_reg);

    always_comb
    begin
        priority if (fw_ext < WW'(gmt_pkg::MIN_DIM))
            w_eff = WW'(gmt_pkg::MIN_DIM);
        else if (fw_ext > WW'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = fw_ext;
    end

    assign h_eff = (fh_reg < RW'(gmt_pkg::MIN_DIM)) ? RW'(gmt_pkg::MIN_DIM) : fh_reg;

    // control and datapath state
    gmt_pkg::gmt_state_t state_reg, state_next;

    logic [CW-1:0]         col_reg;
    logic [RCW-1:0]        row_reg;
    logic [PW-1:0]         pix_reg;
    logic [PW-1:0]         win_reg [3];
    logic [PW-1:0]         up_dly_reg;
    logic [PW-1:0]         dn_dly_reg;
    logic [DW-1:0]         ax_reg;
    logic [DW-1:0]         ay_reg;
    logic [RW-1:0]         orow_reg;
    logic [gmt_pkg::COL_W-1:0] ocol_reg;
    logic                  last_reg;
    logic                  inner_reg;

    logic                  out_valid_reg;
    logic [PW-1:0]         out_mag_reg;
    logic [PW-1:0]         out_edge_reg;
    logic [RW-1:0]         out_row_reg;
    logic [gmt_pkg::COL_W-1:0] out_col_reg;
    logic                  out_last_reg;

    logic                  accept;
    logic                  calc;
    logic                  emit_now;
    logic                  last_now;
    logic                  inner_now;
    logic [WW-1:0]         c_ext;
    logic [RW-1:0]         orow_now;
    logic [WW-1:0]         ocol_now;
    logic [DW-1:0]         mid_half;
    logic [DW-1:0]         left_half;
    logic [DW-1:0]         up_half;
    logic [DW-1:0]         dn_half;
    logic [DW-1:0]         ax_now;
    logic [DW-1:0]         ay_now;
    logic                  out_free;
    logic                  out_load;

    logic [PW-1:0]         rd_up;
    logic [PW-1:0]         rd_mid;

    logic                  sqrt_start;
    logic                  sqrt_busy;
    logic                  sqrt_done;
    logic [gmt_pkg::ROOT_W-1:0] sqrt_root;
    logic [2*DW-1:0]       sq_x;
    logic [2*DW-1:0]       sq_y;
    logic [gmt_pkg::SQ_W-1:0] sq_sum;

    assign accept = pix_in.valid && pix_in.ready;
    assign calc   = state_reg == gmt_pkg::ST_CALC;

    // line stores: read at request time, written back in the calc cycle;
    // the fsm holds off the next request so read and write never overlap
    gmt_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_WIDTH)
    ) u_line_upper (
        .clk   (clk),
        .we    (calc),
        .waddr (col_reg),
        .wdata (rd_mid),
        .re    (accept),
        .raddr (col_reg),
        .rdata (rd_up)
    );

    gmt_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_WIDTH)
    ) u_line_middle (
        .clk   (clk),
        .we    (calc),
        .waddr (col_reg),
        .wdata (pix_reg),
        .re    (accept),
        .raddr (col_reg),
        .rdata (rd_mid)
    );

    // centre is one row and one column behind the input position
    assign c_ext     = WW'(col_reg);
    assign last_now  = row_reg >= ({1'b0, h_eff} + RCW'(1));
    assign emit_now  = (row_reg >= RCW'(2)) || ((row_reg == RCW'(1)) && (col_reg != '0));
    assign orow_now  = (col_reg == '0) ? RW'(row_reg - RCW'(2)) : RW'(row_reg - RCW'(1));
    assign ocol_now  = (col_reg == '0) ? (w_eff - WW'(1)) : (c_ext - WW'(1));
    assign inner_now = (orow_now != '0) && (orow_now < (h_eff - RW'(1)))
                       && (ocol_now != '0) && (ocol_now < (w_eff - WW'(1)));

    assign mid_half  = rd_mid[PW-1:1];
    assign left_half = win_reg[1][PW-1:1];
    assign up_half   = up_dly_reg[PW-1:1];
    assign dn_half   = dn_dly_reg[PW-1:1];
    assign ax_now    = (mid_half >= left_half) ? (mid_half - left_half) : (left_half - mid_half);
    assign ay_now    = (up_half >= dn_half) ? (up_half - dn_half) : (dn_half - up_half);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= gmt_pkg::ST_IDLE;
            col_reg    <= '0;
            row_reg    <= '0;
            win_reg[0] <= '0;
            win_reg[1] <= '0;
            win_reg[2] <= '0;
            up_dly_reg <= '0;
            dn_dly_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (calc)
            begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= win_reg[2];
                win_reg[2] <= rd_mid;
                up_dly_reg <= rd_up;
                dn_dly_reg <= pix_reg;
                if (last_now)
                begin
                    col_reg <= '0;
                    row_reg <= '0;
                end
                else if ((c_ext + WW'(1)) >= w_eff)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + RCW'(1);
                end
                else
                begin
                    col_reg <= col_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg <= pix_in.flush ? '0 : pix_in.pixel;
        end
        if (calc)
        begin
            ax_reg    <= ax_now;
            ay_reg    <= ay_now;
            orow_reg  <= orow_now;
            ocol_reg  <= ocol_now[gmt_pkg::COL_W-1:0];
            last_reg  <= last_now;
            inner_reg <= inner_now;
        end
    end

    // squared gradient and square root
    assign sq_x   = ax_reg * ax_reg;
    assign sq_y   = ay_reg * ay_reg;
    assign sq_sum = {1'b0, sq_x} + {1'b0, sq_y};

    gmt_isqrt u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sqrt_start),
        .operand (sq_sum),
        .busy    (sqrt_busy),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    assign out_free = !out_valid_reg || res_out.ready;

    always_comb
    begin
        state_next   = state_reg;
        sqrt_start   = 1'b0;
        out_load     = 1'b0;
        pix_in.ready = 1'b0;
        unique case (state_reg)
            gmt_pkg::ST_IDLE:
            begin
                pix_in.ready = 1'b1;
                if (pix_in.valid)
                begin
                    state_next = gmt_pkg::ST_CALC;
                end
            end
            gmt_pkg::ST_CALC:
            begin
                state_next = emit_now ? gmt_pkg::ST_SQUARE : gmt_pkg::ST_IDLE;
            end
            gmt_pkg::ST_SQUARE:
            begin
                sqrt_start = 1'b1;
                state_next = gmt_pkg::ST_ROOT;
            end
            gmt_pkg::ST_ROOT:
            begin
                if (sqrt_done)
                begin
                    state_next = gmt_pkg::ST_EMIT;
                end
            end
            gmt_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = gmt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gmt_pkg::ST_IDLE;
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_mag_reg  <= inner_reg ? PW'(sqrt_root) : '0;
            out_edge_reg <= (inner_reg && (PW'(sqrt_root) >= thr_reg)) ? gmt_pkg::EDGE_ON
                                                                       : gmt_pkg::EDGE_OFF;
            out_row_reg  <= orow_reg;
            out_col_reg  <= ocol_reg;
            out_last_reg <= last_reg;
        end
    end

    assign res_out.valid      = out_valid_reg;
    assign res_out.magnitude  = out_mag_reg;
    assign res_out.edge_value = out_edge_reg;
    assign res_out.row_index  = out_row_reg;
    assign res_out.col_index  = out_col_reg;
    assign res_out.frame_last = out_last_reg;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_start |-> !sqrt_busy)
        else $error("square root started while busy");

    a_accept_calc: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == gmt_pkg::ST_CALC))
        else $error("accepted pixel not processed next cycle");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (calc && last_now) |=> ((col_reg == '0) && (row_reg == '0)))
        else $error("counters not cleared at frame end");

    a_edge_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid |-> ((res_out.edge_value == gmt_pkg::EDGE_ON)
                           || (res_out.edge_value == gmt_pkg::EDGE_OFF)))
        else $error("edge value neither on nor off");
`endif

endmodule

`default_nettype wire

/* rtl/gmt_ram.sv */
// generic single-port-write ram with registered read
`default_nettype none

module gmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire                       clk,
    input  wire                       we,
    input  wire  [$clog2(DEPTH)-1:0]  waddr,
    input  wire  [WIDTH-1:0]          wdata,
    input  wire                       re,
    input  wire  [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/gmt_isqrt.sv */
// iterative integer square root, one result bit per cycle
`default_nettype none

module gmt_isqrt (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              start,
    input  wire  [gmt_pkg::SQ_W-1:0]         operand,
    output logic                             busy,
    output logic                             done,
    output logic [gmt_pkg::ROOT_W-1:0]       root
);

    logic                      busy_reg;
    logic                      done_reg;
    logic [gmt_pkg::SQ_W-1:0]  rem_reg;
    logic [gmt_pkg::SQ_W-1:0]  res_reg;
    logic [gmt_pkg::SQ_W-1:0]  bit_reg;
    logic [gmt_pkg::SQ_W:0]    trial;
    logic                      take;

    assign trial = {1'b0, res_reg} + {1'b0, bit_reg};
    assign take  = {1'b0, rem_reg} >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && bit_reg[0])
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= operand;
            res_reg <= '0;
            bit_reg <= gmt_pkg::SQ_TOP;
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                rem_reg <= rem_reg - trial[gmt_pkg::SQ_W-1:0];
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign root = res_reg[gmt_pkg::ROOT_W-1:0];

endmodule

`default_nettype wire

/* verif/gradient_magnitude_threshold_core_test.sv */
// testbench of the gradient magnitude threshold core: random and directed frames checked
module gradient_magnitude_threshold_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         LINE_DEPTH   = gmt_pkg::MAX_WIDTH_DEF;
    localparam int         LINE_FILL_W  = 24;
    localparam int         DRAIN_CYCLES = 24;
    localparam int         RANDOM_ITEMS = 1000;
    localparam logic [8:0] PAD          = 9'h100;

    typedef struct packed {
        logic [gmt_pkg::PIX_W-1:0] magnitude;
        logic [gmt_pkg::PIX_W-1:0] edge_value;
        logic [gmt_pkg::ROW_W-1:0] row_index;
        logic [gmt_pkg::COL_W-1:0] col_index;
        logic                      frame_last;
    } gradient_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [gmt_pkg::PADDR_W-1:0] paddr;
    logic [gmt_pkg::PDATA_W-1:0] pwdata;
    logic [gmt_pkg::PDATA_W-1:0] prdata;
    logic pready;

    gmt_pix_if pix_if ();
    gmt_res_if res_if ();

    gradient_magnitude_threshold_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_if),
        .res_out (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // mirror of the block state
    logic [gmt_pkg::PIX_W-1:0] up_store [LINE_DEPTH];
    logic [gmt_pkg::PIX_W-1:0] mid_store [LINE_DEPTH];
    logic [gmt_pkg::PIX_W-1:0] mid_window [3];
    logic [gmt_pkg::PIX_W-1:0] up_hold;
    logic [gmt_pkg::PIX_W-1:0] down_hold;
    int                        col_count;
    int                        row_count;
    logic [gmt_pkg::PIX_W-1:0] thr_shadow;
    logic [gmt_pkg::FW_W-1:0]  width_shadow;
    logic [gmt_pkg::ROW_W-1:0] height_shadow;

    gradient_t gradient_results_due[$];
    int        mismatch_count;
    int        items_sent;
    int        send_idle_pct;
    int        recv_stall_pct;

    always #5 clk = ~clk;

    initial
    begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    always @(negedge clk)
    begin
        res_if.ready = ($urandom_range(99) >= recv_stall_pct);
    end

    task report_mismatch(input string what, input int want, input int got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch %s: expected %0d, got %0d", what, want, got);
    endtask

    always @(posedge clk)
    begin : check_results
        gradient_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (gradient_results_due.size() == 0)
            begin
                report_mismatch("result with none pending, row", -1, res_if.row_index);
            end
            else
            begin
                want = gradient_results_due.pop_front();
                if (res_if.magnitude !== want.magnitude)
                    report_mismatch("magnitude", want.magnitude, res_if.magnitude);
                if (res_if.edge_value !== want.edge_value)
                    report_mismatch("edge_value", want.edge_value, res_if.edge_value);
                if (res_if.row_index !== want.row_index)
                    report_mismatch("row_index", want.row_index, res_if.row_index);
                if (res_if.col_index !== want.col_index)
                    report_mismatch("col_index", want.col_index, res_if.col_index);
                if (res_if.frame_last !== want.frame_last)
                    report_mismatch("frame_last", want.frame_last, res_if.frame_last);
            end
        end
    end

    function automatic int floor_root(input int v);
        int r;
        r = 0;
        while ((r + 1) * (r + 1) <= v)
            r++;
        return r;
    endfunction

    function automatic int eff_width();
        int w;
        w = width_shadow;
        if (w < gmt_pkg::MIN_DIM)
            w = gmt_pkg::MIN_DIM;
        if (w > LINE_DEPTH)
            w = LINE_DEPTH;
        return w;
    endfunction

    function automatic int eff_height();
        return (height_shadow < gmt_pkg::MIN_DIM) ? gmt_pkg::MIN_DIM : int'(height_shadow);
    endfunction

    task compute_gradient(input logic [gmt_pkg::PIX_W-1:0] pix, input logic fl);
        int                        w;
        int                        h;
        int                        ci;
        int                        orow;
        int                        ocol;
        int                        gx;
        int                        gy;
        int                        mag;
        logic [gmt_pkg::PIX_W-1:0] p;
        logic [gmt_pkg::PIX_W-1:0] upv;
        logic [gmt_pkg::PIX_W-1:0] midv;
        logic                      last_flag;
        gradient_t                 res;
        w = eff_width();
        h = eff_height();
        ci = col_count % LINE_DEPTH;
        p = fl ? '0 : pix;
        upv = up_store[ci];
        midv = mid_store[ci];
        up_store[ci] = midv;
        mid_store[ci] = p;
        mid_window[0] = mid_window[1];
        mid_window[1] = mid_window[2];
        mid_window[2] = midv;
        last_flag = (row_count >= h + 1);
        if (row_count >= 2 || (row_count == 1 && col_count >= 1))
        begin
            orow = (col_count == 0) ? row_count - 2 : row_count - 1;
            ocol = (col_count == 0) ? w - 1 : col_count - 1;
            res.magnitude = '0;
            res.edge_value = gmt_pkg::EDGE_OFF;
            if (orow != 0 && orow < h - 1 && ocol != 0 && ocol < w - 1)
            begin
                gx = int'(mid_window[2] >> 1) - int'(mid_window[0] >> 1);
                gy = int'(up_hold >> 1) - int'(down_hold >> 1);
                mag = floor_root(gx * gx + gy * gy);
                res.magnitude = gmt_pkg::PIX_W'(mag);
                res.edge_value = (mag >= thr_shadow) ? gmt_pkg::EDGE_ON : gmt_pkg::EDGE_OFF;
            end
            res.row_index = gmt_pkg::ROW_W'(orow);
            res.col_index = gmt_pkg::COL_W'(ocol);
            res.frame_last = last_flag;
            gradient_results_due.push_back(res);
        end
        up_hold = upv;
        down_hold = p;
        if (last_flag)
        begin
            col_count = 0;
            row_count = 0;
        end
        else if (col_count + 1 >= w)
        begin
            col_count = 0;
            row_count = row_count + 1;
        end
        else
        begin
            col_count = col_count + 1;
        end
    endtask

    task send_pixel(input logic [gmt_pkg::PIX_W-1:0] pix, input logic fl);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix_if.valid = 1'b0;
            @(negedge clk);
        end
        pix_if.valid = 1'b1;
        pix_if.pixel = pix;
        pix_if.flush = fl;
        @(posedge clk);
        while (!pix_if.ready)
            @(posedge clk);
        compute_gradient(pix, fl);
        items_sent++;
    endtask

    task input_quiet();
        @(negedge clk);
        pix_if.valid = 1'b0;
    endtask

    task wait_drained();
        while (gradient_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [gmt_pkg::PDATA_W-1:0] shadow_of(input gmt_pkg::gmt_reg_t idx);
        case (idx)
            gmt_pkg::REG_THRESHOLD:    return gmt_pkg::PDATA_W'(thr_shadow);
            gmt_pkg::REG_FRAME_WIDTH:  return gmt_pkg::PDATA_W'(width_shadow);
            gmt_pkg::REG_FRAME_HEIGHT: return gmt_pkg::PDATA_W'(height_shadow);
            default:                   return '0;
        endcase
    endfunction

    task read_reg(input gmt_pkg::gmt_reg_t idx);
        logic [gmt_pkg::PDATA_W-1:0] got;
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = {idx, 2'b00};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        got = prdata;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        if (got !== shadow_of(idx))
            report_mismatch(idx.name(), shadow_of(idx), got);
    endtask

    task write_reg(input gmt_pkg::gmt_reg_t idx, input logic [gmt_pkg::PDATA_W-1:0] value);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            gmt_pkg::REG_THRESHOLD:    thr_shadow = value[gmt_pkg::PIX_W-1:0];
            gmt_pkg::REG_FRAME_WIDTH:  width_shadow = value[gmt_pkg::FW_W-1:0];
            gmt_pkg::REG_FRAME_HEIGHT: height_shadow = value[gmt_pkg::ROW_W-1:0];
            default:                   ;
        endcase
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        read_reg(idx);
    endtask

    task set_frame(input int thr, input int w, input int h);
        wait_drained();
        write_reg(gmt_pkg::REG_THRESHOLD, thr);
        write_reg(gmt_pkg::REG_FRAME_WIDTH, w);
        write_reg(gmt_pkg::REG_FRAME_HEIGHT, h);
    endtask

    task retune_mid_frame();
        wait_drained();
        case ($urandom_range(2))
            0:       write_reg(gmt_pkg::REG_THRESHOLD, $urandom_range(255));
            1:       write_reg(gmt_pkg::REG_FRAME_WIDTH, $urandom_range(gmt_pkg::MIN_DIM, 20));
            default: write_reg(gmt_pkg::REG_FRAME_HEIGHT, $urandom_range(gmt_pkg::MIN_DIM, 12));
        endcase
    endtask

    // runs items until the frame counters wrap back to the start
    task stream_frame(input int retune_at, input logic smooth);
        int                        sent;
        logic                      fl;
        logic [gmt_pkg::PIX_W-1:0] pix;
        sent = 0;
        do
        begin
            if (sent == retune_at)
            begin
                input_quiet();
                retune_mid_frame();
            end
            pix = smooth ? gmt_pkg::PIX_W'($urandom_range(100, 131))
                         : gmt_pkg::PIX_W'($urandom_range(255));
            if (row_count < eff_height())
                fl = ($urandom_range(19) == 0);
            else
                fl = ($urandom_range(3) != 0);
            send_pixel(pix, fl);
            sent++;
        end
        while (row_count != 0 || col_count != 0);
        input_quiet();
    endtask

    task test_register_reset();
        read_reg(gmt_pkg::REG_THRESHOLD);
        read_reg(gmt_pkg::REG_FRAME_WIDTH);
        read_reg(gmt_pkg::REG_FRAME_HEIGHT);
    endtask

    // line wider than any later frame, fills every line store entry used later
    task test_line_fill();
        set_frame(0, LINE_FILL_W, 1);
        stream_frame(-1, 1'b0);
    endtask

    task test_directed_patterns();
        logic [8:0] steep_rise [13];
        logic [8:0] steep_fall [13];
        steep_rise = '{PAD, 9'd255, 9'd7, 9'd0, 9'd90, 9'd255, 9'd33, 9'd0, 9'd200,
                       9'd255, 9'd128, 9'd1, 9'd255};
        steep_fall = '{9'd128, 9'd0, 9'd64, 9'd255, 9'd1, 9'd0, 9'd3, 9'd255, PAD,
                       PAD, PAD, PAD, PAD};
        set_frame(179, 2, 3);
        foreach (steep_rise[i])
            send_pixel(steep_rise[i][7:0], steep_rise[i][8]);
        input_quiet();
        set_frame(255, 1, 0);
        foreach (steep_fall[i])
            send_pixel(steep_fall[i][7:0], steep_fall[i][8]);
        input_quiet();
    endtask

    // tallest frame, cut short by lowering the height mid-frame
    task test_tall_frame_cut();
        set_frame(90, 3, 65535);
        repeat (150)
            send_pixel(gmt_pkg::PIX_W'($urandom_range(255)), $urandom_range(15) == 0);
        input_quiet();
        wait_drained();
        write_reg(gmt_pkg::REG_FRAME_HEIGHT, 4);
        stream_frame(-1, 1'b0);
        stream_frame(-1, 1'b1);
    endtask

    task test_random_frames();
        int first;
        int phase;
        int w;
        int h;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS)
        begin
            phase = (items_sent - first) * 4 / RANDOM_ITEMS;
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            w = ($urandom_range(7) == 0) ? $urandom_range(0, 2)
                                         : $urandom_range(gmt_pkg::MIN_DIM, 16);
            h = ($urandom_range(7) == 0) ? $urandom_range(0, 2)
                                         : $urandom_range(gmt_pkg::MIN_DIM, 10);
            set_frame($urandom_range(200), w, h);
            if ($urandom_range(7) == 0)
                stream_frame($urandom_range(1, eff_width() * eff_height()),
                             1'($urandom_range(1)));
            else
                stream_frame(-1, 1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pix_if.valid = 1'b0;
        pix_if.pixel = '0;
        pix_if.flush = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        items_sent = 0;
        foreach (up_store[i])
        begin
            up_store[i] = '0;
            mid_store[i] = '0;
        end
        foreach (mid_window[i])
            mid_window[i] = '0;
        up_hold = '0;
        down_hold = '0;
        col_count = 0;
        row_count = 0;
        thr_shadow = gmt_pkg::THRESHOLD_RST;
        width_shadow = gmt_pkg::WIDTH_RST;
        height_shadow = gmt_pkg::HEIGHT_RST;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_register_reset();
        test_line_fill();
        test_directed_patterns();
        test_tall_frame_cut();
        test_random_frames();

        wait_drained();
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/gmt_pkg.sv
rtl/gmt_if.sv
rtl/gmt_ram.sv
rtl/gmt_isqrt.sv
rtl/gradient_magnitude_threshold_core.sv
verif/gradient_magnitude_threshold_core_test.sv
